FILE: hw/rtl/alst_pkg.sv
// Shared types and codes for the aging LRU sighting table.
`timescale 1ns / 1ps
package alst_pkg;

    localparam logic [2:0] EV_ADDED     = 3'd0;
    localparam logic [2:0] EV_REFRESHED = 3'd1;
    localparam logic [2:0] EV_EXPIRED   = 3'd2;
    localparam logic [2:0] EV_EVICTED   = 3'd3;
    localparam logic [2:0] EV_DONE      = 3'd4;

    localparam logic OP_SIGHT  = 1'b0;
    localparam logic OP_COMMIT = 1'b1;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd1;

    localparam logic [2:0] SRC_NONE = 3'd0;
    localparam logic [2:0] SRC_HIT  = 3'd1;
    localparam logic [2:0] SRC_OLD  = 3'd2;
    localparam logic [2:0] SRC_CUR  = 3'd3;
    localparam logic [2:0] SRC_NEW  = 3'd4;

    typedef struct packed {
        logic        op;
        logic [31:0] item_id;
        logic [15:0] road_id;
        logic [7:0]  item_kind;
        logic [30:0] now_ms;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [31:0] out_id;
        logic [15:0] out_road;
        logic [7:0]  out_kind;
        logic [4:0]  entry_count;
        logic        last;
    } out_beat_t;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] road;
        logic [7:0]  kind;
        logic [30:0] last_seen;
    } slot_t;

    typedef struct packed {
        logic       load;
        logic       clr_best;
        logic       zero_idx;
        logic       next_idx;
        logic       scan_hit;
        logic       scan_old;
        logic       kill;
        logic       kill_old;
        logic       wr_refresh;
        logic       wr_new;
        logic       wr_new_old;
        logic       emit;
        logic [2:0] emit_ev;
        logic [2:0] emit_src;
        logic       emit_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic idx_end;
        logic cur_valid;
        logic cur_aged;
        logic hit_found;
        logic free_found;
        logic over_cap;
        logic out_free;
        logic is_commit;
    } dp_status_t;

endpackage

FILE: hw/rtl/alst_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module alst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hw/rtl/alst_ctrl.sv
// Sequencer for sightings and commits of the sighting table.
`timescale 1ns / 1ps
module alst_ctrl import alst_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RD    = 4'd1;
    localparam logic [3:0] ST_EV    = 4'd2;
    localparam logic [3:0] ST_DEC   = 4'd3;
    localparam logic [3:0] ST_ADD   = 4'd4;
    localparam logic [3:0] ST_CHK   = 4'd5;
    localparam logic [3:0] ST_CRD   = 4'd6;
    localparam logic [3:0] ST_CEV   = 4'd7;
    localparam logic [3:0] ST_EVICT = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    cmd.zero_idx = 1'b1;
                    cmd.clr_best = 1'b1;
                    state_next   = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_EV;
            end
            ST_EV:
            begin
                if (status.is_commit)
                begin
                    if (status.cur_valid && status.cur_aged && !status.out_free)
                    begin
                        state_next = ST_EV;
                    end
                    else
                    begin
                        if (status.cur_valid && status.cur_aged)
                        begin
                            cmd.kill     = 1'b1;
                            cmd.emit     = 1'b1;
                            cmd.emit_ev  = EV_EXPIRED;
                            cmd.emit_src = SRC_CUR;
                        end
                        if (status.idx_end)
                        begin
                            state_next = ST_CHK;
                        end
                        else
                        begin
                            cmd.next_idx = 1'b1;
                            state_next   = ST_RD;
                        end
                    end
                end
                else
                begin
                    cmd.scan_hit = 1'b1;
                    if (status.idx_end)
                    begin
                        state_next = ST_DEC;
                    end
                    else
                    begin
                        cmd.next_idx = 1'b1;
                        state_next   = ST_RD;
                    end
                end
            end
            ST_DEC:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    priority if (status.hit_found)
                    begin
                        cmd.wr_refresh = 1'b1;
                        cmd.emit_ev    = EV_REFRESHED;
                        cmd.emit_src   = SRC_HIT;
                        cmd.emit_last  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else if (status.free_found)
                    begin
                        cmd.wr_new    = 1'b1;
                        cmd.emit_ev   = EV_ADDED;
                        cmd.emit_src  = SRC_NEW;
                        cmd.emit_last = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        cmd.kill     = 1'b1;
                        cmd.kill_old = 1'b1;
                        cmd.emit_ev  = EV_EVICTED;
                        cmd.emit_src = SRC_OLD;
                        state_next   = ST_ADD;
                    end
                end
            end
            ST_ADD:
            begin
                if (status.out_free)
                begin
                    cmd.wr_new     = 1'b1;
                    cmd.wr_new_old = 1'b1;
                    cmd.emit       = 1'b1;
                    cmd.emit_ev    = EV_ADDED;
                    cmd.emit_src   = SRC_NEW;
                    cmd.emit_last  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_CHK:
            begin
                if (status.over_cap)
                begin
                    cmd.zero_idx = 1'b1;
                    cmd.clr_best = 1'b1;
                    state_next   = ST_CRD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CRD:
            begin
                state_next = ST_CEV;
            end
            ST_CEV:
            begin
                cmd.scan_old = 1'b1;
                if (status.idx_end)
                begin
                    state_next = ST_EVICT;
                end
                else
                begin
                    cmd.next_idx = 1'b1;
                    state_next   = ST_CRD;
                end
            end
            ST_EVICT:
            begin
                if (status.out_free)
                begin
                    cmd.kill     = 1'b1;
                    cmd.kill_old = 1'b1;
                    cmd.emit     = 1'b1;
                    cmd.emit_ev  = EV_EVICTED;
                    cmd.emit_src = SRC_OLD;
                    state_next   = ST_CHK;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_ev   = EV_DONE;
                    cmd.emit_src  = SRC_NONE;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/alst_dp.sv
// Datapath of the sighting table: slot store, scan trackers, output register.
`timescale 1ns / 1ps
module alst_dp import alst_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_beat_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_beat_t             out_data,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int SW = $bits(slot_t);

    logic [30:0]        max_age_reg;
    logic [4:0]         capacity_reg;
    in_beat_t           in_reg;
    logic [IW-1:0]      idx_reg;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               hit_found_reg, free_found_reg, old_found_reg;
    logic [IW-1:0]      hit_slot_reg, free_slot_reg, old_slot_reg;
    slot_t              hit_data_reg, old_data_reg;
    logic               out_valid_reg;
    out_beat_t          out_data_reg;

    slot_t              cur;
    logic [SW-1:0]      rd_word;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    slot_t              wr_data;
    logic [30:0]        age;
    logic               old_better;
    logic [IW-1:0]      kill_slot;
    logic [IW-1:0]      new_slot;

    alst_ram #(
        .WIDTH (SW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_reg),
        .rd_data (rd_word)
    );

    assign cur        = slot_t'(rd_word);
    assign age        = in_reg.now_ms - cur.last_seen;
    assign old_better = !old_found_reg || (cur.last_seen < old_data_reg.last_seen);
    assign kill_slot  = cmd.kill_old ? old_slot_reg : idx_reg;
    assign new_slot   = cmd.wr_new_old ? old_slot_reg : free_slot_reg;

    always_comb
    begin
        wr_en   = cmd.wr_refresh || cmd.wr_new;
        wr_addr = cmd.wr_refresh ? hit_slot_reg : new_slot;
        if (cmd.wr_refresh)
        begin
            wr_data           = hit_data_reg;
            wr_data.last_seen = in_reg.now_ms;
        end
        else
        begin
            wr_data = '{id: in_reg.item_id, road: in_reg.road_id,
                        kind: in_reg.item_kind, last_seen: in_reg.now_ms};
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (cmd.kill)
        begin
            valid_next[kill_slot] = 1'b0;
            count_next            = count_reg - CW'(1);
        end
        else if (cmd.wr_new)
        begin
            valid_next[new_slot] = 1'b1;
            count_next           = count_reg + CW'(1);
        end
    end

    assign status.idx_end    = (idx_reg == IW'(ENTRIES - 1));
    assign status.cur_valid  = valid_reg[idx_reg];
    assign status.cur_aged   = (in_reg.now_ms > cur.last_seen) && (age > max_age_reg);
    assign status.hit_found  = hit_found_reg;
    assign status.free_found = free_found_reg;
    assign status.over_cap   = 32'(count_reg) > 32'(capacity_reg);
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.is_commit  = (in_reg.op == OP_COMMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_age_reg    <= 31'd1000;
            capacity_reg   <= 5'd16;
            valid_reg      <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            old_found_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == REG_MAX_AGE)
                begin
                    max_age_reg <= cfg_data;
                end
                else if (cfg_addr == REG_CAPACITY)
                begin
                    capacity_reg <= cfg_data[4:0];
                end
            end
            valid_reg <= valid_next;
            count_reg <= count_next;
            if (cmd.zero_idx)
            begin
                idx_reg <= '0;
            end
            else if (cmd.next_idx)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
            if (cmd.clr_best)
            begin
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
                old_found_reg  <= 1'b0;
            end
            else if ((cmd.scan_hit || cmd.scan_old) && valid_reg[idx_reg])
            begin
                if (cmd.scan_hit && !hit_found_reg && (cur.id == in_reg.item_id))
                begin
                    hit_found_reg <= 1'b1;
                end
                if (old_better)
                begin
                    old_found_reg <= 1'b1;
                end
            end
            else if (cmd.scan_hit && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= in_data;
        end
        if ((cmd.scan_hit || cmd.scan_old) && valid_reg[idx_reg])
        begin
            if (cmd.scan_hit && !hit_found_reg && (cur.id == in_reg.item_id))
            begin
                hit_slot_reg <= idx_reg;
                hit_data_reg <= cur;
            end
            if (old_better)
            begin
                old_slot_reg <= idx_reg;
                old_data_reg <= cur;
            end
        end
        else if (cmd.scan_hit && !free_found_reg)
        begin
            free_slot_reg <= idx_reg;
        end
        if (cmd.emit)
        begin
            out_data_reg.event_res   <= cmd.emit_ev;
            out_data_reg.entry_count <= 5'(count_next);
            out_data_reg.last        <= cmd.emit_last;
            unique case (cmd.emit_src)
                SRC_HIT:
                begin
                    out_data_reg.out_id   <= hit_data_reg.id;
                    out_data_reg.out_road <= hit_data_reg.road;
                    out_data_reg.out_kind <= hit_data_reg.kind;
                end
                SRC_OLD:
                begin
                    out_data_reg.out_id   <= old_data_reg.id;
                    out_data_reg.out_road <= old_data_reg.road;
                    out_data_reg.out_kind <= old_data_reg.kind;
                end
                SRC_CUR:
                begin
                    out_data_reg.out_id   <= cur.id;
                    out_data_reg.out_road <= cur.road;
                    out_data_reg.out_kind <= cur.kind;
                end
                SRC_NEW:
                begin
                    out_data_reg.out_id   <= in_reg.item_id;
                    out_data_reg.out_road <= in_reg.road_id;
                    out_data_reg.out_kind <= in_reg.item_kind;
                end
                default:
                begin
                    out_data_reg.out_id   <= '0;
                    out_data_reg.out_road <= '0;
                    out_data_reg.out_kind <= '0;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: hw/rtl/aging_lru_sighting_table_top.sv
// Top level of the aging LRU sighting table.
`timescale 1ns / 1ps
// Holds up to ENTRIES sighted items in a RAM and walks it slot by slot through
// its single read port. A sighting scans all slots for a hit and a free slot,
// then refreshes the hit, adds into the free slot, or evicts the stalest entry
// and adds there. A commit runs the age scan, the final capacity check and the
// done beat, plus a full scan for each capacity eviction; expired beats leave
// during the age scan. Results wait in an output register; a stalled output
// holds the sequencer when it has a new beat until the old one is taken. No
// clearing pass runs after reset: slot valid bits reset to empty at once.
module aging_lru_sighting_table_top import alst_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_beat_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_beat_t             out_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    alst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    alst_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

FILE: hw/rtl/alst_checker.sv
// Port-level assertions for the sighting table, bound to the top level.
`timescale 1ns / 1ps
module alst_checker import alst_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_beat_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.event_res == EV_DONE) |-> out_data.last)
        else $error("done beat without last");

    a_expired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.event_res == EV_EXPIRED) |-> !out_data.last)
        else $error("expired beat marked last");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(out_data.entry_count) <= ENTRIES))
        else $error("entry count above table size");

endmodule

bind aging_lru_sighting_table_top alst_checker #(
    .ENTRIES (ENTRIES)
) u_alst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

FILE: dv/tb_top.sv
// Testbench for the aging LRU sighting table: predicts every result beat and checks it.
`timescale 1ns / 1ps
module tb_top;
    import alst_pkg::*;

    localparam int SLOTS = 16;
    localparam int HOLD_CYCLES = 400;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    in_beat_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_beat_t             out_data;

    aging_lru_sighting_table_top #(.ENTRIES(SLOTS)) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // table shadow
    logic        tbl_valid [SLOTS];
    logic [31:0] tbl_id    [SLOTS];
    logic [15:0] tbl_road  [SLOTS];
    logic [7:0]  tbl_kind  [SLOTS];
    logic [30:0] tbl_seen  [SLOTS];
    logic [30:0] age_limit;
    logic [4:0]  keep_limit;

    out_beat_t   pending_events [$];
    int          errors;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_req;
    int          hold_left;
    logic [30:0] clock_ms;
    logic [31:0] id_pool [24];

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    initial
    begin
        #20000000;
        $display("tb_top: errors");
        $finish;
    end

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (tbl_valid[i])
                n++;
        return n;
    endfunction

    function automatic int stalest_slot();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (tbl_valid[i] && (best < 0 || tbl_seen[i] < tbl_seen[best]))
                best = i;
        end
        return best;
    endfunction

    task automatic push_event(input logic [2:0] ev, input int slot);
        out_beat_t r;
        r.event_res   = ev;
        r.out_id      = (slot >= 0) ? tbl_id[slot] : 32'd0;
        r.out_road    = (slot >= 0) ? tbl_road[slot] : 16'd0;
        r.out_kind    = (slot >= 0) ? tbl_kind[slot] : 8'd0;
        r.entry_count = 5'(live_count());
        r.last        = 1'b0;
        pending_events.push_back(r);
    endtask

    task automatic predict_table(input in_beat_t b);
        int hit;
        int fr;
        int v;
        if (b.op == OP_SIGHT)
        begin
            hit = -1;
            fr = -1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (tbl_valid[i])
                begin
                    if (hit < 0 && tbl_id[i] == b.item_id)
                        hit = i;
                end
                else if (fr < 0)
                    fr = i;
            end
            if (hit >= 0)
            begin
                tbl_seen[hit] = b.now_ms;
                push_event(EV_REFRESHED, hit);
            end
            else
            begin
                if (fr < 0)
                begin
                    fr = stalest_slot();
                    tbl_valid[fr] = 1'b0;
                    push_event(EV_EVICTED, fr);
                end
                tbl_valid[fr] = 1'b1;
                tbl_id[fr]    = b.item_id;
                tbl_road[fr]  = b.road_id;
                tbl_kind[fr]  = b.item_kind;
                tbl_seen[fr]  = b.now_ms;
                push_event(EV_ADDED, fr);
            end
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (tbl_valid[i] && b.now_ms > tbl_seen[i]
                    && (b.now_ms - tbl_seen[i]) > age_limit)
                begin
                    tbl_valid[i] = 1'b0;
                    push_event(EV_EXPIRED, i);
                end
            end
            while (live_count() > int'(keep_limit))
            begin
                v = stalest_slot();
                tbl_valid[v] = 1'b0;
                push_event(EV_EVICTED, v);
            end
            push_event(EV_DONE, -1);
        end
        pending_events[pending_events.size() - 1].last = 1'b1;
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        errors++;
    endtask

    // result beats: sampled mid-cycle, taken at the next rising edge
    initial
    begin
        out_beat_t w;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_events.size() == 0)
                    report("unexpected beat", out_data.out_id, 32'd0);
                else
                begin
                    w = pending_events.pop_front();
                    if (out_data.event_res !== w.event_res)
                        report("event_res", 32'(out_data.event_res), 32'(w.event_res));
                    if (out_data.out_id !== w.out_id)
                        report("out_id", out_data.out_id, w.out_id);
                    if (out_data.out_road !== w.out_road)
                        report("out_road", 32'(out_data.out_road), 32'(w.out_road));
                    if (out_data.out_kind !== w.out_kind)
                        report("out_kind", 32'(out_data.out_kind), 32'(w.out_kind));
                    if (out_data.entry_count !== w.entry_count)
                        report("entry_count", 32'(out_data.entry_count),
                               32'(w.entry_count));
                    if (out_data.last !== w.last)
                        report("last", 32'(out_data.last), 32'(w.last));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_beat(input in_beat_t b);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_data <= b;
        if (in_valid !== 1'b1)
            in_valid <= 1'b1;
        forever
        begin
            @(negedge clk);
            if (in_ready)
                break;
        end
        @(posedge clk);
        predict_table(b);
    endtask

    task automatic wait_idle();
        if (in_valid)
            in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] val);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        if (idx == REG_MAX_AGE)
            age_limit = val;
        else
            keep_limit = val[4:0];
    endtask

    function automatic in_beat_t make_beat(input logic op, input logic [31:0] id,
                                           input logic [15:0] road, input logic [7:0] kind,
                                           input logic [30:0] now);
        in_beat_t b;
        b.op = op;
        b.item_id = id;
        b.road_id = road;
        b.item_kind = kind;
        b.now_ms = now;
        return b;
    endfunction

    task automatic test_directed();
        write_reg(REG_MAX_AGE, 31'd1000);
        write_reg(REG_CAPACITY, 31'd16);
        send_beat(make_beat(OP_SIGHT, 32'd0, 16'd0, 8'd0, 31'd0));
        for (int i = 1; i < 15; i++)
            send_beat(make_beat(OP_SIGHT, 32'h1000 + i, 16'(i * 7), 8'(i * 3), 31'(i * 10)));
        send_beat(make_beat(OP_SIGHT, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 31'd150));
        // refresh reports stored road and kind
        send_beat(make_beat(OP_SIGHT, 32'd0, 16'hFFFF, 8'hFF, 31'd160));
        // full table: evict the stalest
        send_beat(make_beat(OP_SIGHT, 32'h5555_AAAA, 16'h5A5A, 8'hA5, 31'd200));
        // time going backwards
        send_beat(make_beat(OP_COMMIT, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 31'd100));
        write_reg(REG_CAPACITY, 31'd0);
        send_beat(make_beat(OP_COMMIT, 32'd0, 16'd0, 8'd0, 31'd300));
        write_reg(REG_MAX_AGE, 31'd0);
        write_reg(REG_CAPACITY, 31'd31);
        send_beat(make_beat(OP_SIGHT, 32'd7, 16'd1, 8'd1, 31'd500));
        send_beat(make_beat(OP_SIGHT, 32'd8, 16'd2, 8'd2, 31'd500));
        send_beat(make_beat(OP_COMMIT, 32'd0, 16'd0, 8'd0, 31'd501));
        write_reg(REG_MAX_AGE, 31'h7FFF_FFFF);
        send_beat(make_beat(OP_SIGHT, 32'd9, 16'd3, 8'd3, 31'd0));
        send_beat(make_beat(OP_COMMIT, 32'd0, 16'd0, 8'd0, 31'h7FFF_FFFF));
        write_reg(REG_CAPACITY, 31'd1);
        send_beat(make_beat(OP_COMMIT, 32'd0, 16'd0, 8'd0, 31'h7FFF_FFFF));
        clock_ms = 31'd1000;
    endtask

    function automatic in_beat_t random_beat();
        in_beat_t b;
        int sel;
        b = make_beat(OP_SIGHT, $urandom, 16'($urandom), 8'($urandom), 31'd0);
        sel = $urandom_range(99);
        if (sel < 12)
            b.op = OP_COMMIT;
        else if (sel < 85)
            b.item_id = id_pool[$urandom_range(23)];
        if ($urandom_range(99) < 5 && clock_ms > 31'd300)
            b.now_ms = clock_ms - 31'($urandom_range(300));
        else
        begin
            clock_ms = clock_ms + 31'($urandom_range(120));
            b.now_ms = clock_ms;
        end
        return b;
    endfunction

    task automatic test_random(input int idle_pct, input int stall_pct, input int n);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        write_reg(REG_MAX_AGE, 31'($urandom_range(600, 20)));
        if ($urandom_range(3) == 0)
            write_reg(REG_CAPACITY, 31'($urandom_range(31)));
        else
            write_reg(REG_CAPACITY, 31'($urandom_range(16, 4)));
        for (int i = 0; i < n; i++)
            send_beat(random_beat());
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(REG_CAPACITY, 31'd16);
        write_reg(REG_MAX_AGE, 31'd5000);
        hold_req = 1'b1;
        for (int i = 0; i < 24; i++)
            send_beat(random_beat());
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        hold_left = 0;
        clock_ms = 31'd0;
        age_limit = 31'd1000;
        keep_limit = 5'd16;
        for (int i = 0; i < SLOTS; i++)
            tbl_valid[i] = 1'b0;
        for (int i = 0; i < 24; i++)
            id_pool[i] = $urandom;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(0, 0, 70);
        test_random(49, 0, 70);
        test_random(0, 49, 70);
        test_random(19, 19, 70);
        test_backpressure();
        test_random(19, 19, 20);

        wait_idle();
        repeat (700) @(posedge clk);
        if (errors == 0 && pending_events.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/alst_pkg.sv
hw/rtl/alst_ram.sv
hw/rtl/alst_ctrl.sv
hw/rtl/alst_dp.sv
hw/rtl/aging_lru_sighting_table_top.sv
hw/rtl/alst_checker.sv
dv/tb_top.sv
